// File: sv/bdvd_pkg.sv
`default_nettype none

package bdvd_pkg;

	localparam int MAX_RESULTS = 32;

	localparam logic [3:0] FN_ADD_FRONT  = 4'd0;
	localparam logic [3:0] FN_ADD_BACK   = 4'd1;
	localparam logic [3:0] FN_DEL_FRONT  = 4'd2;
	localparam logic [3:0] FN_DEL_BACK   = 4'd3;
	localparam logic [3:0] FN_CLEAR      = 4'd4;
	localparam logic [3:0] FN_DEL_VALUE  = 4'd5;
	localparam logic [3:0] FN_LIST_ALL   = 4'd6;
	localparam logic [3:0] FN_LIST_FIRST = 4'd7;
	localparam logic [3:0] FN_LIST_LAST  = 4'd8;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ELEM   = 1'b1;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] item;
		logic [1:0]         status;
		logic               last;
	} res_t;

	typedef enum logic [2:0] {
		C_HOLD,
		C_FROM_LEFT,
		C_FROM_RIGHT,
		C_WRITE,
		C_SCAN_CLR,
		C_SCAN,
		C_DELETE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DELV,
		S_ROT
	} state_t;

endpackage

`default_nettype wire

// File: sv/bounded_deque_with_value_delete.sv
`default_nettype none

// channel  | valid     | ready     | payload
// command  | cmd_valid | cmd_ready | cmd (func, value)
// result   | res_valid | res_ready | res (kind, item, status, last)
//
// delete by value on a non-empty list scans the row first: the match flag ripples
// listings of at least one entry rotate the row once round
// stalls on res_ready hold the row; a new command is taken while a result waits
// reset clears count and control; stored values come up undefined

module bounded_deque_with_value_delete #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_ready,
	input  wire bdvd_pkg::cmd_t cmd,
	output logic                res_valid,
	input  wire                 res_ready,
	output bdvd_pkg::res_t      res
);
	import bdvd_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;
	cmd_t   cmd_q;
	res_t   res_q, res_d;
	logic   res_valid_q, res_load;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] rot_q, rot_d;
	logic [CW-1:0] n_q, ws_q;
	logic          back_q;

	cell_ctrl_t            cell_ctrl;
	logic [DATA_WIDTH-1:0] key;
	logic [DATA_WIDTH-1:0] left0;
	logic [DATA_WIDTH-1:0] data [CAPACITY];
	logic [CAPACITY-1:0]   pre;
	logic [DATA_WIDTH-1:0] end_data;
	logic signed [31:0]    end_item;

	logic          can_load, empty, full, is_list, to_scan, to_rot, rot_last;
	logic [31:0]   cnt32, lim32, n32;
	logic [CW-1:0] n_d, ws_d;
	logic [CW:0]   win_end;
	logic          emit, step, emit_last;

	if (DATA_WIDTH <= 32) begin : g_key_narrow
		assign key = cmd_q.value[DATA_WIDTH-1:0];
	end else begin : g_key_wide
		assign key = {{(DATA_WIDTH-32){cmd_q.value[31]}}, cmd_q.value};
	end

	assign end_data = back_q ? data[CAPACITY-1] : data[0];

	if (DATA_WIDTH >= 32) begin : g_item_wide
		assign end_item = end_data[31:0];
	end else begin : g_item_narrow
		assign end_item = {{(32-DATA_WIDTH){end_data[DATA_WIDTH-1]}}, end_data};
	end

	assign left0 = (state_q == S_EXEC) ? key : data[CAPACITY-1];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] l_data, r_data;
		logic                  p_in;
		if (i == 0) begin : g_first
			assign l_data = left0;
			assign p_in   = 1'b0;
		end else begin : g_mid
			assign l_data = data[i-1];
			assign p_in   = pre[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign r_data = data[0];
		end else begin : g_inner
			assign r_data = data[i+1];
		end
		bdvd_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.sel        (count_q == CW'(i)),
			.in_use     (CW'(i) < count_q),
			.key        (key),
			.left_data  (l_data),
			.right_data (r_data),
			.pre_in     (p_in),
			.data       (data[i]),
			.pre        (pre[i])
		);
	end

	assign can_load = !res_valid_q || res_ready;
	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(CAPACITY));
	assign is_list  = (cmd_q.func == FN_LIST_ALL) || (cmd_q.func == FN_LIST_FIRST) ||
		(cmd_q.func == FN_LIST_LAST);

	always_comb begin
		cnt32 = cmd_q.value[31] ? 32'd0 : 32'(cmd_q.value);
		lim32 = 32'(count_q);
		if (lim32 > 32'(MAX_RESULTS)) begin
			lim32 = 32'(MAX_RESULTS);
		end
		if (cmd_q.func == FN_LIST_ALL || cnt32 > lim32) begin
			n32 = lim32;
		end else begin
			n32 = cnt32;
		end
	end

	assign n_d      = n32[CW-1:0];
	assign ws_d     = (cmd_q.func == FN_LIST_LAST) ? (CW'(CAPACITY) - count_q) : '0;
	assign to_scan  = (cmd_q.func == FN_DEL_VALUE) && !empty;
	assign to_rot   = is_list && !empty && (n_d != '0);
	assign rot_last = (rot_q == CW'(CAPACITY - 1));

	assign win_end   = {1'b0, ws_q} + {1'b0, n_q};
	assign emit      = (rot_q >= ws_q) && ({1'b0, rot_q} < win_end);
	assign emit_last = ({1'b0, rot_q} + (CW+1)'(1)) == win_end;
	assign step      = !emit || can_load;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (to_scan) begin
					state_d = S_SCAN;
				end else if (to_rot) begin
					state_d = S_ROT;
				end else if (can_load) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (rot_last) begin
					state_d = S_DELV;
				end
			end
			S_DELV: begin
				if (can_load) begin
					state_d = S_IDLE;
				end
			end
			S_ROT: begin
				if (step && rot_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cell_ctrl.op = C_HOLD;
		res_load     = 1'b0;
		res_d.kind   = KIND_STATUS;
		res_d.item   = '0;
		res_d.status = ST_OK;
		res_d.last   = 1'b1;
		count_d      = count_q;
		rot_d        = rot_q;
		case (state_q)
			S_EXEC: begin
				rot_d = '0;
				if (to_scan) begin
					cell_ctrl.op = C_SCAN_CLR;
				end else if (!to_rot && can_load) begin
					res_load = 1'b1;
					case (cmd_q.func)
						FN_ADD_FRONT, FN_ADD_BACK: begin
							if (full) begin
								res_d.status = ST_FULL;
							end else begin
								cell_ctrl.op = (cmd_q.func == FN_ADD_FRONT) ?
									C_FROM_LEFT : C_WRITE;
								count_d = count_q + CW'(1);
							end
						end
						FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_VALUE: begin
							if (empty) begin
								res_d.status = ST_EMPTY;
							end else begin
								if (cmd_q.func == FN_DEL_FRONT) begin
									cell_ctrl.op = C_FROM_RIGHT;
								end
								count_d = count_q - CW'(1);
							end
						end
						FN_CLEAR: count_d = '0;
						FN_LIST_ALL, FN_LIST_FIRST, FN_LIST_LAST: begin
							res_d.status = empty ? ST_EMPTY : ST_OK;
						end
						default: res_d.status = ST_OK;
					endcase
				end
			end
			S_SCAN: begin
				cell_ctrl.op = C_SCAN;
				rot_d        = rot_q + CW'(1);
			end
			S_DELV: begin
				if (can_load) begin
					res_load = 1'b1;
					if (pre[CAPACITY-1]) begin
						cell_ctrl.op = C_DELETE;
						count_d      = count_q - CW'(1);
					end else begin
						res_d.status = ST_NOT_FOUND;
					end
				end
			end
			S_ROT: begin
				if (step) begin
					cell_ctrl.op = back_q ? C_FROM_LEFT : C_FROM_RIGHT;
					rot_d        = rot_q + CW'(1);
				end
				if (emit && can_load) begin
					res_load   = 1'b1;
					res_d.kind = KIND_ELEM;
					res_d.item = end_item;
					res_d.last = emit_last;
				end
			end
			default: cell_ctrl.op = C_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rot_q       <= '0;
			res_valid_q <= 1'b0;
			back_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rot_q       <= rot_d;
			res_valid_q <= res_load | (res_valid_q & ~res_ready);
			if (state_q == S_EXEC && to_rot) begin
				back_q <= (cmd_q.func == FN_LIST_LAST);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
		if (state_q == S_EXEC && to_rot) begin
			n_q  <= n_d;
			ws_q <= ws_d;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (state_q == S_EXEC))
		else $error("accepted command not executed");

	a_elem_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res_d.kind == KIND_ELEM) |-> (state_q == S_ROT && emit))
		else $error("element result outside listing window");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		($past(state_q) == S_EXEC || $past(state_q) == S_DELV))
		else $error("count changed outside update states");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> can_load)
		else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

// File: sv/bdvd_cell.sv
`default_nettype none

module bdvd_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  bdvd_pkg::cell_ctrl_t  ctrl,
	input  wire                         sel,
	input  wire                         in_use,
	input  wire  [DATA_WIDTH-1:0]       key,
	input  wire  [DATA_WIDTH-1:0]       left_data,
	input  wire  [DATA_WIDTH-1:0]       right_data,
	input  wire                         pre_in,
	output logic [DATA_WIDTH-1:0]       data,
	output logic                        pre
);
	import bdvd_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  pre_q;
	logic                  match;

	assign match = in_use && (data_q == key);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			C_FROM_LEFT:  data_q <= left_data;
			C_FROM_RIGHT: data_q <= right_data;
			C_WRITE: begin
				if (sel) begin
					data_q <= key;
				end
			end
			C_DELETE: begin
				if (pre_q) begin
					data_q <= right_data;
				end
			end
			default: data_q <= data_q;
		endcase
	end

	// running first-match flag, one cell further each cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= 1'b0;
		end else begin
			case (ctrl.op)
				C_SCAN_CLR: pre_q <= 1'b0;
				C_SCAN:     pre_q <= pre_in | match;
				default:    pre_q <= pre_q;
			endcase
		end
	end

	assign data = data_q;
	assign pre  = pre_q;

endmodule

`default_nettype wire

// File: dv/bdvd_checker.sv
module bdvd_checker #(
	parameter int CAPACITY = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cmd_valid,
	input  wire            cmd_ready,
	input  bdvd_pkg::cmd_t cmd,
	input  wire            res_valid,
	input  wire            res_ready,
	input  bdvd_pkg::res_t res,
	output int             errors,
	output int             pending
);
	import bdvd_pkg::*;

	logic signed [31:0] deque_vals [CAPACITY];
	int                 deque_head;
	int                 deque_size;
	res_t               awaited_res [$];
	res_t               want;

	function automatic int slot_of(int i);
		return (deque_head + i) % CAPACITY;
	endfunction

	function automatic void expect_status(logic [1:0] st);
		res_t r;
		r = '{kind: KIND_STATUS, item: '0, status: st, last: 1'b1};
		awaited_res.push_back(r);
	endfunction

	function automatic void expect_listing(int n, bit from_tail);
		res_t r;
		int   pos;
		if (deque_size == 0) begin
			expect_status(ST_EMPTY);
			return;
		end
		if (n > deque_size)
			n = deque_size;
		if (n > MAX_RESULTS)
			n = MAX_RESULTS;
		if (n == 0) begin
			expect_status(ST_OK);
			return;
		end
		for (int i = 0; i < n; i++) begin
			pos = from_tail ? deque_size - 1 - i : i;
			r = '{kind: KIND_ELEM, item: deque_vals[slot_of(pos)], status: ST_OK,
				last: (i + 1 == n)};
			awaited_res.push_back(r);
		end
	endfunction

	function automatic void apply_command(cmd_t c);
		int n;
		int hit;
		n = c.value[31] ? 0 : int'(c.value);
		hit = -1;
		case (c.func)
		FN_ADD_FRONT, FN_ADD_BACK: begin
			if (deque_size >= CAPACITY) begin
				expect_status(ST_FULL);
			end else begin
				if (c.func == FN_ADD_FRONT) begin
					deque_head = (deque_head + CAPACITY - 1) % CAPACITY;
					deque_vals[deque_head] = c.value;
				end else begin
					deque_vals[slot_of(deque_size)] = c.value;
				end
				deque_size++;
				expect_status(ST_OK);
			end
		end
		FN_DEL_FRONT, FN_DEL_BACK: begin
			if (deque_size == 0) begin
				expect_status(ST_EMPTY);
			end else begin
				if (c.func == FN_DEL_FRONT)
					deque_head = slot_of(1);
				deque_size--;
				expect_status(ST_OK);
			end
		end
		FN_CLEAR: begin
			deque_head = 0;
			deque_size = 0;
			expect_status(ST_OK);
		end
		FN_DEL_VALUE: begin
			if (deque_size == 0) begin
				expect_status(ST_EMPTY);
			end else begin
				for (int i = 0; i < deque_size && hit < 0; i++)
					if (deque_vals[slot_of(i)] == c.value)
						hit = i;
				if (hit < 0) begin
					expect_status(ST_NOT_FOUND);
				end else begin
					// close the gap towards the front
					for (int j = hit; j + 1 < deque_size; j++)
						deque_vals[slot_of(j)] = deque_vals[slot_of(j + 1)];
					deque_size--;
					expect_status(ST_OK);
				end
			end
		end
		FN_LIST_ALL:   expect_listing(deque_size, 1'b0);
		FN_LIST_FIRST: expect_listing(n, 1'b0);
		FN_LIST_LAST:  expect_listing(n, 1'b1);
		default:       expect_status(ST_OK);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deque_head = 0;
			deque_size = 0;
			awaited_res.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cmd_valid && cmd_ready)
				apply_command(cmd);
			if (res_valid && res_ready) begin
				if (awaited_res.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: kind %0d item %0d status %0d last %0d",
						$time, res.kind, res.item, res.status, res.last);
				end else begin
					want = awaited_res.pop_front();
					if (res !== want) begin
						errors++;
						$display("%0t: expected kind %0d item %0d status %0d last %0d, got kind %0d item %0d status %0d last %0d",
							$time, want.kind, want.item, want.status, want.last,
							res.kind, res.item, res.status, res.last);
					end
				end
			end
			pending = awaited_res.size();
		end
	end

endmodule

// File: dv/tb_bounded_deque_with_value_delete.sv
module tb_bounded_deque_with_value_delete;
	import bdvd_pkg::*;

	localparam int CAPACITY    = 32;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_results = 1'b0;
	int errors;
	int pending;
	int cycles = 0;

	always #2 clk = ~clk;

	bounded_deque_with_value_delete #(
		.CAPACITY(CAPACITY),
		.DATA_WIDTH(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	bdvd_checker #(
		.CAPACITY(CAPACITY)
	) results_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.errors(errors),
		.pending(pending)
	);

	function automatic logic signed [31:0] rand_value();
		logic signed [31:0] corners [4];
		corners = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1};
		case ($urandom_range(3))
		0:       return int'($urandom_range(6)) - 3;
		1:       return corners[$urandom_range(3)];
		default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_count();
		case ($urandom_range(3))
		0:       return int'($urandom_range(40));
		1:       return -int'($urandom_range(100));
		2:       return $urandom;
		default: return int'($urandom_range(3));
		endcase
	endfunction

	task automatic send_cmd(input logic [3:0] f, input logic signed [31:0] v);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{func: f, value: v};
		do @(posedge clk); while (!cmd_ready);
	endtask

	// sender stays quiet until every awaited result has arrived
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// clear, overfill by two, then list and delete on a full row
	task automatic fill_run();
		send_cmd(FN_CLEAR, rand_value());
		repeat (CAPACITY + 2)
			send_cmd($urandom_range(1) ? FN_ADD_FRONT : FN_ADD_BACK, rand_value());
		send_cmd(FN_LIST_ALL, rand_value());
		send_cmd(FN_LIST_LAST, CAPACITY + 1);
		send_cmd(FN_DEL_VALUE, rand_value());
	endtask

	task automatic run_random(input int n);
		int         add_pct;
		int         r;
		logic [3:0] f;
		add_pct = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 20 == 0)
				add_pct = 25 + 25 * int'($urandom_range(2));
			r = $urandom_range(99);
			if (r < add_pct) begin
				send_cmd(r[0] ? FN_ADD_FRONT : FN_ADD_BACK, rand_value());
			end else begin
				case ($urandom_range(11))
				0, 1:    f = FN_DEL_FRONT;
				2, 3:    f = FN_DEL_BACK;
				4, 5:    f = FN_DEL_VALUE;
				6:       f = FN_LIST_ALL;
				7, 8:    f = FN_LIST_FIRST;
				9:       f = FN_LIST_LAST;
				10:      f = FN_CLEAR;
				default: f = 4'(9 + $urandom_range(6));
				endcase
				if (f == FN_LIST_FIRST || f == FN_LIST_LAST)
					send_cmd(f, rand_count());
				else
					send_cmd(f, rand_value());
			end
		end
	endtask

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_results) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end
			res_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 38;
		recv_idle_pct = 83;

		// empty list cases
		send_cmd(FN_DEL_FRONT, 32'sd0);
		send_cmd(FN_DEL_BACK, 32'sd0);
		send_cmd(FN_DEL_VALUE, 32'sd5);
		send_cmd(FN_LIST_ALL, 32'sd0);
		send_cmd(FN_LIST_FIRST, 32'sd5);
		send_cmd(FN_LIST_LAST, 32'sd5);
		send_cmd(FN_CLEAR, 32'sd0);
		// extremes of the value field
		send_cmd(FN_ADD_BACK, 32'sh7fffffff);
		send_cmd(FN_ADD_FRONT, 32'sh80000000);
		send_cmd(FN_ADD_BACK, 32'sd0);
		send_cmd(FN_ADD_BACK, -32'sd1);
		// counts of zero, negative and above size
		send_cmd(FN_LIST_FIRST, 32'sd0);
		send_cmd(FN_LIST_LAST, -32'sd5);
		send_cmd(FN_LIST_FIRST, 32'sh80000000);
		send_cmd(FN_LIST_FIRST, 32'sd100);
		send_cmd(FN_LIST_LAST, 32'sd2);
		send_cmd(FN_DEL_VALUE, 32'sd12345);
		send_cmd(FN_DEL_VALUE, 32'sh80000000);
		send_cmd(FN_LIST_ALL, 32'sd0);
		send_cmd(FN_DEL_FRONT, 32'sd0);
		send_cmd(FN_DEL_BACK, 32'sd0);
		// unused codes
		send_cmd(4'd15, 32'sh7fffffff);
		send_cmd(4'd9, -32'sd1);
		send_cmd(FN_LIST_ALL, 32'sd0);

		fill_run();
		run_random(40);
		wait_drained();

		send_idle_pct = 83;
		recv_idle_pct = 38;
		fill_run();
		run_random(40);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_results = 1'b1;
		fill_run();
		run_random(40);

		wait_drained();
		repeat (2 * CAPACITY + 10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
